>>> src/dssed_pkg.sv
// Package with the shared types and constants of the DoG extremum detector.
`timescale 1ns / 1ps

package dssed_pkg;

  // Difference layers formed from the six input levels
  localparam int unsigned DOG_LAYERS = 5;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DOG_W      = DOG_LAYERS * PIX_W;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_OUT_W  = 10;
  localparam int unsigned THR_W      = 8;
  // Wide enough for counter + 1 and for any line length up to 4096
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CfgImageHeight = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CfgThreshold   = 2'd2;

  localparam logic [WIDTH_W-1:0] WidthReset  = 11'd1024;
  localparam logic [ROW_W-1:0]   HeightReset = 12'd768;
  localparam logic [THR_W-1:0]   ThrReset    = 8'd8;

  // One DoG value per layer
  typedef logic [DOG_LAYERS-1:0][PIX_W-1:0] dog_vec_t;
  // Three rows of one window column, row 0 on top
  typedef dog_vec_t [2:0] dog_col_t;
  // Three window columns, column 0 oldest
  typedef dog_col_t [2:0] dog_win_t;

  // One result request
  typedef struct packed {
    logic             centre_valid;
    logic [ROW_W-1:0] centre_row;
    logic [COL_OUT_W-1:0] centre_col;
    logic             keypoint_scale1;
    logic             keypoint_scale2;
    logic             keypoint_scale3;
  } result_t;

endpackage

>>> src/dssed_line_buffer.sv
// Line memory holding the DoG values of the two previous image lines per column.
`timescale 1ns / 1ps

module dssed_line_buffer #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr_i,
  input  logic [2*dssed_pkg::DOG_W-1:0]        wr_data_i,
  output logic [2*dssed_pkg::DOG_W-1:0]        rd_data_o
);
  import dssed_pkg::*;

  // Entry: {two lines back, previous line}
  logic [2*DOG_W-1:0] mem [DEPTH];
  logic [2*DOG_W-1:0] rdata_q;
  logic [2*DOG_W-1:0] byp_data_q;
  logic               byp_q;
  logic               byp_hit;

  assign byp_hit = wr_en_i && rd_en_i && (wr_addr_i == rd_addr_i);

  // Synchronous write and read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
    if (byp_hit) begin
      byp_data_q <= wr_data_i;
    end
  end

  // Forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= byp_hit;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rdata_q;

endmodule

>>> src/dssed_extremum.sv
// Extremum test of the window centre in DoG layers 1, 2 and 3.
`timescale 1ns / 1ps

module dssed_extremum (
  input  dssed_pkg::dog_win_t          win_i,
  input  logic [dssed_pkg::THR_W-1:0]  threshold_i,
  output logic [2:0]                   keypoint_o
);
  import dssed_pkg::*;

  for (genvar g = 0; g < 3; g++) begin : g_layer
    localparam int unsigned L = g + 1;
    logic [PIX_W-1:0] centre;
    logic             none_greater;
    logic             none_smaller;

    assign centre = win_i[1][1][L];

    // 26 independent compares against the centre
    always_comb begin
      none_greater = 1'b1;
      none_smaller = 1'b1;
      for (int l = 0; l < 3; l++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (!(l == 1 && r == 1 && c == 1)) begin
              if (win_i[c][r][L-1+l] > centre) none_greater = 1'b0;
              if (win_i[c][r][L-1+l] < centre) none_smaller = 1'b0;
            end
          end
        end
      end
    end

    assign keypoint_o[g] = (centre > threshold_i) && (none_greater || none_smaller);
  end

endmodule

>>> src/dssed_out_queue.sv
// Small result queue that decouples the pipeline from a stalling receiver.
`timescale 1ns / 1ps

module dssed_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dssed_pkg::result_t  push_data_i,
  input  logic                pending_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dssed_pkg::result_t  out_data_o
);
  import dssed_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  result_t         entries_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [PW:0]     count_q;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entries_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Leave room for a request in flight plus one more
  assign in_stall_o = ((PW+1)'(count_q) + (PW+1)'(pending_i)) >= (PW+1)'(DEPTH - 1);

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PW'(1);
      if (pop)    rptr_q <= rptr_q + PW'(1);
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop);
    end
  end

endmodule

>>> src/dog_scale_space_extremum_detector_core.sv
// Top level of the DoG scale-space extremum detector.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i / in_stall_o) carries the six pixels of one
// position in raster order: level 0 and five blurred levels. Every request
// produces exactly one result request on the output channel (out_valid_o /
// out_stall_i) for the window centre one row up and one column left.
// Border positions give a result with all fields zero.
// Throughput: one request per clock cycle while in_stall_o is low. Each
// result passes the stage 1 registers and the queue before it is presented.
// The line memory is read when a request is accepted and written back in
// the next cycle; a write to the column being read is forwarded.
// When the receiver stalls, results collect in a four-entry queue and
// in_stall_o rises once queued plus in-flight results reach three.
// Configuration writes (cfg_we_i) take effect at once and are meant to be
// issued while idle. Reset clears the position counters and the window and
// loads the register defaults; line memory contents stay undefined, but the
// first two lines of an image never produce a centre.
module dog_scale_space_extremum_detector_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dssed_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dssed_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         level0_pixel_i,
  input  logic [7:0]                         level1_pixel_i,
  input  logic [7:0]                         level2_pixel_i,
  input  logic [7:0]                         level3_pixel_i,
  input  logic [7:0]                         level4_pixel_i,
  input  logic [7:0]                         level5_pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               centre_valid_o,
  output logic [11:0]                        centre_row_o,
  output logic [9:0]                         centre_col_o,
  output logic                               keypoint_scale1_o,
  output logic                               keypoint_scale2_o,
  output logic                               keypoint_scale3_o
);
  import dssed_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [THR_W-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thr_q    <= ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CfgImageHeight: height_q <= cfg_data_i[ROW_W-1:0];
        CfgThreshold:   thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // Position counters
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] col_inc, row_inc, width_lim;

  always_comb begin
    col_inc   = CNT_W'(col_q) + CNT_W'(1);
    row_inc   = CNT_W'(row_q) + CNT_W'(1);
    width_lim = (CNT_W'(width_q) > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                      : CNT_W'(width_q);
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= width_lim) begin
      col_d = '0;
      if (row_inc >= CNT_W'(height_q) || row_inc > CNT_W'(12'hFFF)) begin
        row_d = '0;
      end else begin
        row_d = row_inc[ROW_W-1:0];
      end
    end else begin
      col_d = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // New DoG values of the arriving position
  logic [PIX_W-1:0] lvl [DOG_LAYERS+1];
  dog_vec_t         dog_new;

  assign lvl[0] = level0_pixel_i;
  assign lvl[1] = level1_pixel_i;
  assign lvl[2] = level2_pixel_i;
  assign lvl[3] = level3_pixel_i;
  assign lvl[4] = level4_pixel_i;
  assign lvl[5] = level5_pixel_i;

  always_comb begin
    for (int i = 0; i < DOG_LAYERS; i++) begin
      dog_new[i] = (lvl[i+1] >= lvl[i]) ? (lvl[i+1] - lvl[i]) : (lvl[i] - lvl[i+1]);
    end
  end

  // Stage 1 registers: memory read in flight
  logic             s1_valid_q;
  logic             s1_centre_q;
  logic [CW-1:0]    s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  dog_vec_t         s1_dog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_centre_q <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_dog_q    <= dog_new;
    end
  end

  // Line memory: read at accept, write back from stage 1
  logic [2*DOG_W-1:0] lb_rd_data;
  logic [2*DOG_W-1:0] lb_wr_data;
  dog_vec_t           line_two_back, line_prev;

  assign line_two_back = lb_rd_data[2*DOG_W-1:DOG_W];
  assign line_prev     = lb_rd_data[DOG_W-1:0];
  assign lb_wr_data    = {line_prev, s1_dog_q};

  dssed_line_buffer #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buffer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wr_data),
    .rd_data_o (lb_rd_data)
  );

  // Window: two stored columns plus the column arriving now
  dog_col_t wcol0_q, wcol1_q, col_new;
  dog_win_t win;

  assign col_new[0] = line_two_back;
  assign col_new[1] = line_prev;
  assign col_new[2] = s1_dog_q;
  assign win[0]     = wcol0_q;
  assign win[1]     = wcol1_q;
  assign win[2]     = col_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol0_q <= '0;
      wcol1_q <= '0;
    end else if (s1_valid_q) begin
      wcol0_q <= wcol1_q;
      wcol1_q <= col_new;
    end
  end

  logic [2:0] keypoint;

  dssed_extremum u_extremum (
    .win_i       (win),
    .threshold_i (thr_q),
    .keypoint_o  (keypoint)
  );

  // Result assembly; border positions give all zero
  result_t res;

  always_comb begin
    res = '0;
    if (s1_centre_q) begin
      res.centre_valid    = 1'b1;
      res.centre_row      = s1_row_q - ROW_W'(1);
      res.centre_col      = COL_OUT_W'(s1_col_q - CW'(1));
      res.keypoint_scale1 = keypoint[0];
      res.keypoint_scale2 = keypoint[1];
      res.keypoint_scale3 = keypoint[2];
    end
  end

  result_t out_res;

  dssed_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (res),
    .pending_i   (s1_valid_q),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign centre_valid_o    = out_res.centre_valid;
  assign centre_row_o      = out_res.centre_row;
  assign centre_col_o      = out_res.centre_col;
  assign keypoint_scale1_o = out_res.keypoint_scale1;
  assign keypoint_scale2_o = out_res.keypoint_scale2;
  assign keypoint_scale3_o = out_res.keypoint_scale3;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the DoG scale-space extremum detector core.
`timescale 1ns / 1ps

module tb_top;
  import dssed_pkg::*;

  localparam int unsigned LineMax      = 1024;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned ReportCap    = 20;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CfgSpare = 2'd3;

  typedef logic [PIX_W-1:0] level_px_t [6];
  typedef enum int {PixNoise, PixNarrow, PixSpiky} pix_mode_e;

  // Tracks the detector state, predicts one result per pixel request and
  // compares the results that come out in order.
  class keypoint_checker;
    logic [WIDTH_W-1:0] width;
    logic [ROW_W-1:0]   height;
    logic [THR_W-1:0]   thr;
    dog_vec_t           line_prev [LineMax];
    dog_vec_t           line_back [LineMax];
    dog_col_t           win_cols [2];
    int unsigned        col;
    int unsigned        row;
    result_t            pending_centres [$];
    int unsigned        mismatches;
    int unsigned        requests;
    int unsigned        checked;
    int unsigned        centres;
    int unsigned        keypoints;

    function new();
      width       = WidthReset;
      height      = HeightReset;
      thr         = ThrReset;
      win_cols[0] = '0;
      win_cols[1] = '0;
      col         = 0;
      row         = 0;
      mismatches  = 0;
      requests    = 0;
      checked     = 0;
      centres     = 0;
      keypoints   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CfgImageWidth:  width  = data[WIDTH_W-1:0];
        CfgImageHeight: height = data[ROW_W-1:0];
        CfgThreshold:   thr    = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Centre above threshold and no strict neighbor above it, or none below
    function bit is_local_extremum(dog_win_t w, int layer);
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] n;
      bit no_greater;
      bit no_smaller;
      v = w[1][1][layer];
      no_greater = 1'b1;
      no_smaller = 1'b1;
      if (v <= thr) return 1'b0;
      for (int l = layer - 1; l <= layer + 1; l++)
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) begin
            if (l == layer && r == 1 && c == 1) continue;
            n = w[c][r][l];
            if (n > v) no_greater = 1'b0;
            if (n < v) no_smaller = 1'b0;
          end
      return no_greater || no_smaller;
    endfunction

    function void take_pixels(level_px_t px);
      dog_vec_t    fresh;
      dog_win_t    w;
      result_t     r;
      int unsigned c;
      int unsigned rw;
      int unsigned wid;
      c   = col;
      rw  = row;
      wid = (width > LineMax) ? LineMax : width;
      if (c >= LineMax) c = 0;
      for (int l = 0; l < DOG_LAYERS; l++)
        fresh[l] = (px[l+1] >= px[l]) ? px[l+1] - px[l] : px[l] - px[l+1];
      w[0]    = win_cols[0];
      w[1]    = win_cols[1];
      w[2][0] = line_back[c];
      w[2][1] = line_prev[c];
      w[2][2] = fresh;
      r = '0;
      if (rw >= 2 && c >= 2) begin
        r.centre_valid    = 1'b1;
        r.centre_row      = ROW_W'(rw - 1);
        r.centre_col      = COL_OUT_W'(c - 1);
        r.keypoint_scale1 = is_local_extremum(w, 1);
        r.keypoint_scale2 = is_local_extremum(w, 2);
        r.keypoint_scale3 = is_local_extremum(w, 3);
      end
      win_cols[0]  = w[1];
      win_cols[1]  = w[2];
      line_back[c] = w[2][1];
      line_prev[c] = fresh;
      // Raster position of the next pixel
      if (c + 1 >= wid) begin
        col = 0;
        row = (rw + 1 >= height) ? 0 : rw + 1;
      end else begin
        col = c + 1;
      end
      requests++;
      pending_centres = {pending_centres, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_centre(result_t got);
      result_t want;
      if (pending_centres.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("%0t: result with none expected, expected nothing actual %h", $time, got);
        return;
      end
      want = pending_centres.pop_front();
      checked++;
      if (want.centre_valid) centres++;
      keypoints += want.keypoint_scale1 + want.keypoint_scale2 + want.keypoint_scale3;
      compare_field("centre_valid", want.centre_valid, got.centre_valid);
      compare_field("centre_row", want.centre_row, got.centre_row);
      compare_field("centre_col", want.centre_col, got.centre_col);
      compare_field("keypoint_scale1", want.keypoint_scale1, got.keypoint_scale1);
      compare_field("keypoint_scale2", want.keypoint_scale2, got.keypoint_scale2);
      compare_field("keypoint_scale3", want.keypoint_scale3, got.keypoint_scale3);
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            level0_pixel_i = '0;
  logic [7:0]            level1_pixel_i = '0;
  logic [7:0]            level2_pixel_i = '0;
  logic [7:0]            level3_pixel_i = '0;
  logic [7:0]            level4_pixel_i = '0;
  logic [7:0]            level5_pixel_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  centre_valid_o;
  logic [11:0]           centre_row_o;
  logic [9:0]            centre_col_o;
  logic                  keypoint_scale1_o;
  logic                  keypoint_scale2_o;
  logic                  keypoint_scale3_o;

  keypoint_checker kp_check;
  int unsigned     gap_free_left = 0;
  int unsigned     quiet_cycles  = 0;
  int unsigned     setups        = 0;
  logic [7:0]      band_base;
  level_px_t       plateau;

  dog_scale_space_extremum_detector_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .level0_pixel_i    (level0_pixel_i),
    .level1_pixel_i    (level1_pixel_i),
    .level2_pixel_i    (level2_pixel_i),
    .level3_pixel_i    (level3_pixel_i),
    .level4_pixel_i    (level4_pixel_i),
    .level5_pixel_i    (level5_pixel_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .centre_valid_o    (centre_valid_o),
    .centre_row_o      (centre_row_o),
    .centre_col_o      (centre_col_o),
    .keypoint_scale1_o (keypoint_scale1_o),
    .keypoint_scale2_o (keypoint_scale2_o),
    .keypoint_scale3_o (keypoint_scale3_o)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic int unsigned input_gap();
    if (gap_free_left != 0) begin
      gap_free_left--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) gap_free_left = $urandom_range(64, 200);
    if ($urandom_range(0, 1) == 0) return 0;
    return random_gap();
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_threshold();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 255));
    return CFG_DATA_W'($urandom_range(0, 40));
  endfunction

  function automatic void make_levels(input pix_mode_e mode, output level_px_t px);
    for (int i = 0; i < 6; i++) begin
      case (mode)
        PixNarrow: px[i] = band_base + 8'($urandom_range(0, 3));
        PixSpiky:  px[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : plateau[i];
        default:   px[i] = 8'($urandom_range(0, 255));
      endcase
    end
  endfunction

  // Output side: free runs, some long, broken by stalls
  initial begin : stall_pattern
    int unsigned run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (random_gap()) @(posedge clk_i);
    end
  end

  // Results are sampled mid-cycle and taken at the next rising edge
  always @(negedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.centre_valid    = centre_valid_o;
      got.centre_row      = centre_row_o;
      got.centre_col      = centre_col_o;
      got.keypoint_scale1 = keypoint_scale1_o;
      got.keypoint_scale2 = keypoint_scale2_o;
      got.keypoint_scale3 = keypoint_scale3_o;
      kp_check.check_centre(got);
    end
  end

  // Ends a hung run
  always @(negedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    kp_check.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One pixel request; returns at the edge that takes it
  task automatic send_levels(input level_px_t px);
    int unsigned gap;
    gap = input_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    level0_pixel_i <= px[0];
    level1_pixel_i <= px[1];
    level2_pixel_i <= px[2];
    level3_pixel_i <= px[3];
    level4_pixel_i <= px[4];
    level5_pixel_i <= px[5];
    in_valid_i     <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    kp_check.take_pixels(px);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (kp_check.pending_centres.size() != 0) @(posedge clk_i);
  endtask

  // Flat images, a lone peak and a lone dip in a 3x3 frame
  task automatic run_directed();
    level_px_t px;
    write_register(CfgSpare, CFG_DATA_W'($urandom_range(0, 4095)));
    write_register(CfgImageWidth, 12'd3);
    write_register(CfgImageHeight, 12'd3);
    write_register(CfgThreshold, 12'd0);
    setups++;
    for (int pic = 0; pic < 3; pic++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          for (int i = 0; i < 6; i++)
            px[i] = (pic == 1) ? 8'h00 : ((i % 2 == 0) ? 8'hFF : 8'h00);
          if (r == 1 && c == 1 && pic != 0) px[3] = (pic == 1) ? 8'hFF : 8'h80;
          send_levels(px);
        end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] t, input int unsigned count,
                           input pix_mode_e mode);
    level_px_t px;
    wait_drained();
    // Mid-image: 1x1 sizes make the next pixel wrap to the image start
    if (kp_check.col != 0 || kp_check.row != 0) begin
      write_register(CfgImageWidth, 12'd1);
      write_register(CfgImageHeight, 12'd1);
      make_levels(PixNoise, px);
      send_levels(px);
      in_valid_i <= 1'b0;
      wait_drained();
    end
    write_register(CfgImageWidth, w);
    write_register(CfgImageHeight, h);
    write_register(CfgThreshold, t);
    setups++;
    band_base = 8'($urandom_range(0, 252));
    for (int i = 0; i < 6; i++) plateau[i] = 8'($urandom_range(0, 255));
    repeat (count) begin
      make_levels(mode, px);
      send_levels(px);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    kp_check = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Register extremes; upper data bits beyond a register are dropped
    run_phase(12'h803, 12'd4095, 12'd6, 3 * 8, PixNoise);
    run_phase(12'hFFF, 12'd3, 12'd10, 40, PixNarrow);
    run_phase(12'd1024, 12'd768, 12'hFFF, 40, PixNoise);

    // Sizes below three never give a centre
    run_phase(12'd0, 12'd6, 12'd0, 24, PixNoise);
    run_phase(12'd1, 12'd1, 12'd0, 12, PixNoise);
    run_phase(12'd2, 12'd7, 12'd0, 24, PixNarrow);
    run_phase(12'd6, 12'd0, 12'd0, 24, PixNoise);
    run_phase(12'd5, 12'd2, 12'd0, 24, PixSpiky);

    run_phase(12'd16, 12'd8, 12'd3, 400, PixSpiky);
    run_phase(12'd33, 12'd5, random_threshold(), 330, PixNarrow);
    run_phase(12'd7, 12'd6, random_threshold(), 300, PixNoise);
    repeat (3)
      run_phase(CFG_DATA_W'($urandom_range(3, 40)), CFG_DATA_W'($urandom_range(3, 12)),
                random_threshold(), $urandom_range(100, 150),
                pix_mode_e'($urandom_range(0, 2)));

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d pixel requests over %0d size and threshold setups.",
             kp_check.requests, setups);
    $display("Checked %0d results: %0d window centres, %0d keypoint flags set.",
             kp_check.checked, kp_check.centres, kp_check.keypoints);
    if (kp_check.mismatches == 0 && kp_check.pending_centres.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
